/* rtl/frt_pkg.sv */
// Shared types and constants for the fragment reassembly tracker.
package frt_pkg;

    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    // Input item kinds
    localparam logic IN_FRAGMENT = 1'b0;
    localparam logic IN_TICK     = 1'b1;

    // Result kinds
    localparam logic [1:0] OUT_SINGLE   = 2'd0;
    localparam logic [1:0] OUT_COMPLETE = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT  = 2'd2;
    localparam logic [1:0] OUT_MISSING  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic        concat_hdr;
        logic [15:0] msg_ref;
        logic [63:0] sender_id;
        logic [7:0]  part_count;
        logic [7:0]  part_seq;
        logic [7:0]  store_index;
        logic        in_storage;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [2:0]  slot_number;
        logic [15:0] out_ref;
        logic [63:0] out_sender;
        logic [7:0]  out_part;
        logic [7:0]  out_store_index;
        logic        delete_ok;
        logic        last;
    } out_item_t;

    // One stored part: what is kept per part position in the part memory.
    typedef struct packed {
        logic [7:0] store_index;
        logic       in_storage;
    } part_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_MATCH,
        ST_FREE,
        ST_CLAIM,
        ST_RECORD,
        ST_CHECK,
        ST_C_RD,
        ST_C_OUT,
        ST_T_SLOT,
        ST_T_RD,
        ST_T_OUT
    } state_t;

endpackage

/* rtl/frt_part_mem.sv */
// Part memory: storage index and stored bit for every part position.
module frt_part_mem #(
    parameter int DEPTH = 50,
    parameter int AW    = 6
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  frt_pkg::part_entry_t wdata,
    input  logic [AW-1:0]       raddr,
    output frt_pkg::part_entry_t rdata
);

    frt_pkg::part_entry_t mem [DEPTH];
    frt_pkg::part_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/frt_seq.sv */
// Sequencer: slot table, part valid bits and the scan / emit state machine.
module frt_seq #(
    parameter int SLOTS          = 5,
    parameter int PARTS_PER_SLOT = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  frt_pkg::in_item_t    item,
    input  logic [31:0]          tick,
    input  logic [31:0]          timeout,
    input  logic                 out_free,
    output logic                 emit_valid,
    output frt_pkg::out_item_t   emit,
    output logic                 busy
);

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PIW = $clog2(PARTS_PER_SLOT);
    localparam int PCW = $clog2(PARTS_PER_SLOT + 1);
    localparam int DEPTH = SLOTS * PARTS_PER_SLOT;
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SW-1:0]  LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [PCW-1:0] PPS_C     = PCW'(PARTS_PER_SLOT);
    localparam logic [AW-1:0]  PPS_A     = AW'(PARTS_PER_SLOT);

    frt_pkg::state_t state_reg, state_next;
    logic [SW-1:0]   s_reg, s_next;
    logic [SW-1:0]   pick_reg, pick_next;
    logic [31:0]     best_reg, best_next;
    logic [PCW-1:0]  j_reg, j_next;
    logic [PCW-1:0]  lim_reg, lim_next;
    frt_pkg::in_item_t item_reg, item_next;

    logic [SLOTS-1:0]        used_reg, used_next;
    logic [15:0]             ref_reg [SLOTS];
    logic [15:0]             ref_next [SLOTS];
    logic [63:0]             sender_reg [SLOTS];
    logic [63:0]             sender_next [SLOTS];
    logic [7:0]              total_reg [SLOTS];
    logic [7:0]              total_next [SLOTS];
    logic [PCW-1:0]          rcvd_reg [SLOTS];
    logic [PCW-1:0]          rcvd_next [SLOTS];
    logic [31:0]             start_reg [SLOTS];
    logic [31:0]             start_next [SLOTS];
    logic [SLOTS-1:0][PARTS_PER_SLOT-1:0] valid_reg, valid_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    frt_pkg::part_entry_t  mem_wdata;
    frt_pkg::part_entry_t  mem_rdata;

    logic [7:0]                pn_m1;
    logic                      in_range;
    logic [PIW-1:0]            pidx;
    logic [PIW-1:0]            jidx;
    logic [PARTS_PER_SLOT-1:0] row;
    logic                      cur_valid;
    logic                      more;
    logic [31:0]               elapsed;
    logic                      key_hit;
    logic                      older;

    frt_part_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pn_m1     = item_reg.part_seq - 8'd1;
    assign in_range  = item_reg.part_seq <= 8'(PARTS_PER_SLOT);
    assign pidx      = pn_m1[PIW-1:0];
    assign jidx      = j_reg[PIW-1:0];
    assign row       = valid_reg[s_reg];
    assign cur_valid = row[jidx];
    assign elapsed   = tick - start_reg[s_reg];
    assign key_hit   = used_reg[s_reg] && ref_reg[s_reg] == item_reg.msg_ref
                       && sender_reg[s_reg] == item_reg.sender_id;
    assign older     = start_reg[s_reg] < best_reg;
    assign mem_raddr = AW'(s_reg) * PPS_A + AW'(j_reg);
    assign mem_waddr = AW'(s_reg) * PPS_A + AW'(pidx);
    assign mem_wdata = '{store_index: item_reg.store_index, in_storage: item_reg.in_storage};
    assign busy      = state_reg != frt_pkg::ST_IDLE;

    // Any valid part left above j within the scan range
    always_comb begin
        more = 1'b0;
        for (int k = 0; k < PARTS_PER_SLOT; k++) begin
            if (PCW'(k) > j_reg && PCW'(k) < lim_reg && row[k]) begin
                more = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frt_pkg::ST_IDLE;
            used_reg  <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg    <= s_next;
        pick_reg <= pick_next;
        best_reg <= best_next;
        j_reg    <= j_next;
        lim_reg  <= lim_next;
        item_reg <= item_next;
        ref_reg    <= ref_next;
        sender_reg <= sender_next;
        total_reg  <= total_next;
        rcvd_reg   <= rcvd_next;
        start_reg  <= start_next;
    end

    always_comb begin
        state_next  = state_reg;
        s_next      = s_reg;
        pick_next   = pick_reg;
        best_next   = best_reg;
        j_next      = j_reg;
        lim_next    = lim_reg;
        item_next   = item_reg;
        used_next   = used_reg;
        valid_next  = valid_reg;
        ref_next    = ref_reg;
        sender_next = sender_reg;
        total_next  = total_reg;
        rcvd_next   = rcvd_reg;
        start_next  = start_reg;
        mem_we      = 1'b0;
        emit_valid  = 1'b0;
        emit.out_kind        = frt_pkg::OUT_COMPLETE;
        emit.slot_number     = 3'(s_reg);
        emit.out_ref         = ref_reg[s_reg];
        emit.out_sender      = sender_reg[s_reg];
        emit.out_part        = 8'(j_reg) + 8'd1;
        emit.out_store_index = mem_rdata.store_index;
        emit.delete_ok       = mem_rdata.in_storage;
        emit.last            = !more;

        unique case (state_reg)
            frt_pkg::ST_IDLE: begin
                if (start) begin
                    item_next = item;
                    s_next    = '0;
                    if (item.kind == frt_pkg::IN_TICK) begin
                        state_next = frt_pkg::ST_T_SLOT;
                    end else if (item.concat_hdr && item.part_count > 8'd1
                                 && item.part_seq != 8'd0) begin
                        state_next = frt_pkg::ST_MATCH;
                    end else begin
                        state_next = frt_pkg::ST_SINGLE;
                    end
                end
            end
            frt_pkg::ST_SINGLE: begin
                emit_valid           = 1'b1;
                emit.out_kind        = frt_pkg::OUT_SINGLE;
                emit.slot_number     = 3'd0;
                emit.out_ref         = item_reg.msg_ref;
                emit.out_sender      = item_reg.sender_id;
                emit.out_part        = 8'd1;
                emit.out_store_index = item_reg.store_index;
                emit.delete_ok       = item_reg.in_storage;
                emit.last            = 1'b1;
                if (out_free) begin
                    s_next     = '0;
                    state_next = frt_pkg::ST_T_SLOT;
                end
            end
            frt_pkg::ST_MATCH: begin
                if (key_hit) begin
                    state_next = frt_pkg::ST_RECORD;
                end else if (s_reg == LAST_SLOT) begin
                    s_next     = '0;
                    best_next  = '1;
                    pick_next  = '0;
                    state_next = frt_pkg::ST_FREE;
                end else begin
                    s_next = s_reg + SW'(1);
                end
            end
            frt_pkg::ST_FREE: begin
                if (!used_reg[s_reg]) begin
                    state_next = frt_pkg::ST_CLAIM;
                end else begin
                    if (older) begin
                        best_next = start_reg[s_reg];
                        pick_next = s_reg;
                    end
                    if (s_reg == LAST_SLOT) begin
                        s_next     = older ? s_reg : pick_reg;
                        state_next = frt_pkg::ST_CLAIM;
                    end else begin
                        s_next = s_reg + SW'(1);
                    end
                end
            end
            frt_pkg::ST_CLAIM: begin
                used_next[s_reg]   = 1'b1;
                ref_next[s_reg]    = item_reg.msg_ref;
                sender_next[s_reg] = item_reg.sender_id;
                total_next[s_reg]  = item_reg.part_count;
                rcvd_next[s_reg]   = '0;
                start_next[s_reg]  = tick;
                valid_next[s_reg]  = '0;
                state_next         = frt_pkg::ST_RECORD;
            end
            frt_pkg::ST_RECORD: begin
                if (in_range && !row[pidx]) begin
                    valid_next[s_reg][pidx] = 1'b1;
                    mem_we                  = 1'b1;
                    rcvd_next[s_reg]        = rcvd_reg[s_reg] + PCW'(1);
                end
                state_next = frt_pkg::ST_CHECK;
            end
            frt_pkg::ST_CHECK: begin
                if (8'(rcvd_reg[s_reg]) >= item_reg.part_count) begin
                    j_next     = '0;
                    lim_next   = (item_reg.part_count < 8'(PARTS_PER_SLOT))
                                 ? PCW'(item_reg.part_count) : PPS_C;
                    state_next = frt_pkg::ST_C_RD;
                end else begin
                    s_next     = '0;
                    state_next = frt_pkg::ST_T_SLOT;
                end
            end
            frt_pkg::ST_C_RD: begin
                if (j_reg >= lim_reg) begin
                    used_next[s_reg] = 1'b0;
                    s_next           = '0;
                    state_next       = frt_pkg::ST_T_SLOT;
                end else if (cur_valid) begin
                    state_next = frt_pkg::ST_C_OUT;
                end else begin
                    j_next = j_reg + PCW'(1);
                end
            end
            frt_pkg::ST_C_OUT: begin
                emit_valid = 1'b1;
                if (out_free) begin
                    j_next     = j_reg + PCW'(1);
                    state_next = frt_pkg::ST_C_RD;
                end
            end
            frt_pkg::ST_T_SLOT: begin
                if (used_reg[s_reg] && elapsed >= timeout) begin
                    j_next     = '0;
                    lim_next   = (total_reg[s_reg] < 8'(PARTS_PER_SLOT))
                                 ? PCW'(total_reg[s_reg]) : PPS_C;
                    state_next = frt_pkg::ST_T_RD;
                end else if (s_reg == LAST_SLOT) begin
                    state_next = frt_pkg::ST_IDLE;
                end else begin
                    s_next = s_reg + SW'(1);
                end
            end
            frt_pkg::ST_T_RD: begin
                if (j_reg >= lim_reg) begin
                    used_next[s_reg] = 1'b0;
                    if (s_reg == LAST_SLOT) begin
                        state_next = frt_pkg::ST_IDLE;
                    end else begin
                        s_next     = s_reg + SW'(1);
                        state_next = frt_pkg::ST_T_SLOT;
                    end
                end else begin
                    state_next = frt_pkg::ST_T_OUT;
                end
            end
            frt_pkg::ST_T_OUT: begin
                emit_valid = 1'b1;
                emit.last  = j_reg == lim_reg - PCW'(1);
                if (cur_valid) begin
                    emit.out_kind = frt_pkg::OUT_TIMEOUT;
                end else begin
                    emit.out_kind        = frt_pkg::OUT_MISSING;
                    emit.out_store_index = 8'd0;
                    emit.delete_ok       = 1'b0;
                end
                if (out_free) begin
                    j_next     = j_reg + PCW'(1);
                    state_next = frt_pkg::ST_T_RD;
                end
            end
            default: begin
                state_next = frt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/fragment_reassembly_tracker.sv */
// Top level of the fragment reassembly tracker: ports, timeout, tick counter, result stage.
//
//  channel  | ports                      | beat
//  ---------+----------------------------+-------------------------------------
//  input    | s_valid s_ready s_data     | one fragment or one tick
//  result   | m_valid m_ready m_data     | one emitted part, marker or message
//  config   | cfg_wr_en cfg_wr_data      | timeout_ticks, written at once
//
// An input beat is taken only while the sequencer is idle. A tick runs the timeout
// pass over the slots, a single emits its beat and then runs that pass, and a
// fragment runs key match, free or oldest search, claim, record, check and the
// timeout pass. A completion scans the part positions and emits each stored part;
// a flushed slot emits one beat per part position. Every part read goes through the
// one registered read port of the part memory. Reset clears the slot used and part
// valid bits; timeout_ticks returns to 30000. The result register holds a beat until
// taken, and the sequencer stalls behind it while m_ready is low.
module fragment_reassembly_tracker #(
    parameter int SLOTS          = 5,
    parameter int PARTS_PER_SLOT = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  frt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output frt_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data
);

    logic [31:0]        timeout_reg;
    logic [31:0]        tick_reg;
    logic               m_valid_reg;
    frt_pkg::out_item_t m_data_reg;

    logic               busy;
    logic               accept;
    logic               out_free;
    logic               emit_valid;
    frt_pkg::out_item_t emit;

    assign s_ready  = !busy;
    assign accept   = s_valid && s_ready;
    // Result register can take a new beat when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    frt_seq #(.SLOTS(SLOTS), .PARTS_PER_SLOT(PARTS_PER_SLOT)) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .item       (s_data),
        .tick       (tick_reg),
        .timeout    (timeout_reg),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit       (emit),
        .busy       (busy)
    );

    // Hold timeout and advance time on every tick beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= frt_pkg::TIMEOUT_RESET;
            tick_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (accept && s_data.kind == frt_pkg::IN_TICK) begin
                tick_reg <= tick_reg + 32'd1;
            end
        end
    end

    // Load a result when the slot frees up, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid && out_free) begin
            m_data_reg <= emit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/frt_checker.sv */
// Port-level checker for the fragment reassembly tracker, bound to the top level.
module frt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input frt_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

    a_single_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == frt_pkg::OUT_SINGLE
        |-> m_data.last && m_data.out_part == 8'd1 && m_data.slot_number == 3'd0)
        else $error("single message beat malformed");

    a_missing_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == frt_pkg::OUT_MISSING
        |-> !m_data.delete_ok && m_data.out_store_index == 8'd0)
        else $error("missing marker carries storage data");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/sv/frt_checker.sv */
// Checker for the fragment reassembly tracker: predicts every result beat and compares it.
module frt_scoreboard (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  frt_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  frt_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 5;
    localparam int NPART = 10;

    logic [31:0] timeout_ticks;
    logic [31:0] ticks;
    logic        used   [NSLOT];
    logic [15:0] sref   [NSLOT];
    logic [63:0] ssnd   [NSLOT];
    logic [7:0]  stotal [NSLOT];
    int          srecv  [NSLOT];
    logic [31:0] sstart [NSLOT];
    logic        pvalid [NSLOT][NPART];
    logic [7:0]  psidx  [NSLOT][NPART];
    logic        pstored[NSLOT][NPART];

    frt_pkg::out_item_t awaited_beats[$];

    assign pending = awaited_beats.size();

    function automatic frt_pkg::out_item_t beat(logic [1:0] k, int slot, logic [15:0] r,
                                                logic [63:0] snd, int part,
                                                logic [7:0] sidx, logic del);
        frt_pkg::out_item_t b;
        b.out_kind        = k;
        b.slot_number     = slot[2:0];
        b.out_ref         = r;
        b.out_sender      = snd;
        b.out_part        = part[7:0];
        b.out_store_index = sidx;
        b.delete_ok       = del;
        b.last            = 1'b0;
        return b;
    endfunction

    task automatic claim(int s, logic [15:0] r, logic [63:0] snd, logic [7:0] tot);
        used[s]   = 1'b1;
        sref[s]   = r;
        ssnd[s]   = snd;
        stotal[s] = tot;
        srecv[s]  = 0;
        sstart[s] = ticks;
        for (int j = 0; j < NPART; j++) pvalid[s][j] = 1'b0;
    endtask

    // Match by key, else take the first free slot, else evict the oldest.
    task automatic pick_slot(logic [15:0] r, logic [63:0] snd, logic [7:0] tot,
                             output int s);
        logic [31:0] oldest;
        int          victim;
        oldest = 32'hFFFF_FFFF;
        victim = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (used[i] && sref[i] == r && ssnd[i] == snd) begin
                s = i;
                return;
            end
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (!used[i]) begin
                claim(i, r, snd, tot);
                s = i;
                return;
            end
            if (sstart[i] < oldest) begin
                oldest = sstart[i];
                victim = i;
            end
        end
        claim(victim, r, snd, tot);
        s = victim;
    endtask

    task automatic track_fragment(frt_pkg::in_item_t it);
        int s;
        int p;
        int lim;
        int first;
        frt_pkg::out_item_t b;
        if (it.kind == frt_pkg::IN_TICK) begin
            ticks = ticks + 32'd1;
        end else if (it.concat_hdr && it.part_count > 1 && it.part_seq > 0) begin
            p = int'(it.part_seq) - 1;
            pick_slot(it.msg_ref, it.sender_id, it.part_count, s);
            if (p < NPART && !pvalid[s][p]) begin
                pvalid[s][p]  = 1'b1;
                psidx[s][p]   = it.store_index;
                pstored[s][p] = it.in_storage;
                srecv[s]++;
            end
            if (srecv[s] >= int'(it.part_count)) begin
                lim   = (it.part_count < NPART) ? int'(it.part_count) : NPART;
                first = awaited_beats.size();
                for (int j = 0; j < lim; j++) begin
                    if (pvalid[s][j])
                        awaited_beats.push_back(beat(frt_pkg::OUT_COMPLETE, s, sref[s],
                                                     ssnd[s], j + 1, psidx[s][j],
                                                     pstored[s][j]));
                end
                if (awaited_beats.size() > first)
                    awaited_beats[awaited_beats.size() - 1].last = 1'b1;
                used[s] = 1'b0;
            end
        end else begin
            b = beat(frt_pkg::OUT_SINGLE, 0, it.msg_ref, it.sender_id, 1, it.store_index,
                     it.in_storage);
            b.last = 1'b1;
            awaited_beats.push_back(b);
        end

        // flush stale slots, marking the holes
        for (int i = 0; i < NSLOT; i++) begin
            if (used[i] && (ticks - sstart[i]) >= timeout_ticks) begin
                lim   = (stotal[i] < NPART) ? int'(stotal[i]) : NPART;
                first = awaited_beats.size();
                for (int j = 0; j < lim; j++) begin
                    if (pvalid[i][j])
                        awaited_beats.push_back(beat(frt_pkg::OUT_TIMEOUT, i, sref[i],
                                                     ssnd[i], j + 1, psidx[i][j],
                                                     pstored[i][j]));
                    else
                        awaited_beats.push_back(beat(frt_pkg::OUT_MISSING, i, sref[i],
                                                     ssnd[i], j + 1, 8'd0, 1'b0));
                end
                if (awaited_beats.size() > first)
                    awaited_beats[awaited_beats.size() - 1].last = 1'b1;
                used[i] = 1'b0;
            end
        end
    endtask

    task automatic report(string what, frt_pkg::out_item_t exp_b,
                          frt_pkg::out_item_t got);
        fail_count++;
        if (fail_count <= 10)
            $display({"mismatch (%s): expected kind=%0d slot=%0d ref=%h snd=%h part=%0d",
                      " sidx=%h del=%b last=%b, got kind=%0d slot=%0d ref=%h snd=%h",
                      " part=%0d sidx=%h del=%b last=%b"},
                     what, exp_b.out_kind, exp_b.slot_number, exp_b.out_ref,
                     exp_b.out_sender, exp_b.out_part, exp_b.out_store_index,
                     exp_b.delete_ok, exp_b.last, got.out_kind, got.slot_number,
                     got.out_ref, got.out_sender, got.out_part, got.out_store_index,
                     got.delete_ok, got.last);
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        frt_pkg::out_item_t exp_b;
        if (!aresetn) begin
            timeout_ticks = frt_pkg::TIMEOUT_RESET;
            ticks = 32'd0;
            for (int i = 0; i < NSLOT; i++) begin
                used[i] = 1'b0; sref[i] = '0; ssnd[i] = '0;
                stotal[i] = '0; srecv[i] = 0; sstart[i] = '0;
                for (int j = 0; j < NPART; j++) pvalid[i][j] = 1'b0;
            end
            awaited_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_beats.size() == 0) begin
                    report("unexpected beat", '0, m_data);
                end else begin
                    exp_b = awaited_beats.pop_front();
                    if (m_data.out_kind != exp_b.out_kind
                        || m_data.slot_number != exp_b.slot_number
                        || m_data.out_ref != exp_b.out_ref
                        || m_data.out_sender != exp_b.out_sender
                        || m_data.out_part != exp_b.out_part
                        || m_data.out_store_index != exp_b.out_store_index
                        || m_data.delete_ok != exp_b.delete_ok
                        || m_data.last != exp_b.last)
                        report("field", exp_b, m_data);
                end
            end
            if (s_valid && s_ready) track_fragment(s_data);
            if (cfg_wr_en) timeout_ticks = cfg_wr_data;
        end
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the fragment reassembly tracker: stimulus, idling and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_WAIT  = 60;    // well past a fragment's full sequencer pass plus the output stage

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    frt_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    frt_pkg::out_item_t m_data;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    int                 fail_count;
    int                 pending;
    int                 cycles;

    bit          steady;     // no idling on either side
    bit          hold_rx;    // ask the receiver for one long hold-off
    logic [63:0] senders[3];
    logic [15:0] refs[4];

    fragment_reassembly_tracker i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    frt_scoreboard i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: end the run if it hangs.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** fragment_reassembly_tracker: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request, none when steady.
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_rx = 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    function automatic frt_pkg::in_item_t frag(bit cat, logic [15:0] r, logic [63:0] snd,
                                               logic [7:0] tot, logic [7:0] pn,
                                               logic [7:0] sidx, bit st);
        frt_pkg::in_item_t it;
        it.kind        = frt_pkg::IN_FRAGMENT;
        it.concat_hdr  = cat;
        it.msg_ref     = r;
        it.sender_id   = snd;
        it.part_count  = tot;
        it.part_seq    = pn;
        it.store_index = sidx;
        it.in_storage  = st;
        return it;
    endfunction

    function automatic frt_pkg::in_item_t rand_item();
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        return frt_pkg::in_item_t'(noise[$bits(frt_pkg::in_item_t)-1:0]);
    endfunction

    function automatic frt_pkg::in_item_t tick();
        frt_pkg::in_item_t it;
        it = rand_item();
        it.kind = frt_pkg::IN_TICK;   // other fields are don't-care noise
        return it;
    endfunction

    // Offer one beat and hold it until it is taken; maybe drop valid first.
    task automatic send(frt_pkg::in_item_t it);
        if (!steady && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        #1;
        while (!s_ready) begin
            @(negedge aclk);
            #1;
        end
        @(posedge aclk);
    endtask

    // Drop valid and wait for every awaited beat, then let the sequencer settle.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One multi-part message from a small key pool, parts shuffled, with
    // dropped parts, duplicates and ticks mixed in.
    task automatic send_message(ref int sent);
        logic [15:0] r;
        logic [63:0] snd;
        int          tot;
        int          order[$];
        int          k;
        r   = refs[$urandom_range(0, 3)];
        snd = senders[$urandom_range(0, 2)];
        tot = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 14) : $urandom_range(2, 6);
        for (int j = 1; j <= tot; j++) order.push_back(j);
        order.shuffle();
        if ($urandom_range(0, 3) == 0) void'(order.pop_back());
        if ($urandom_range(0, 4) == 0) order.push_front(order[order.size() - 1]);
        foreach (order[i]) begin
            if ($urandom_range(0, 3) == 0) begin
                send(tick());
                sent++;
            end
            k = order[i];
            send(frag(1'b1, r, snd, tot[7:0], k[7:0], 8'($urandom), 1'($urandom)));
            sent++;
        end
    endtask

    task automatic random_phase(int target, bit with_pressure);
        int sent;
        bit pressed;
        bit paused;
        sent    = 0;
        pressed = 1'b0;
        paused  = 1'b0;
        while (sent < target) begin
            if (with_pressure && !pressed && sent > target / 4) begin
                hold_rx = 1'b1;   // block stays fed while results back up
                pressed = 1'b1;
            end
            if (with_pressure && !paused && sent > target / 2) begin
                drain();          // sender waits out every awaited beat
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: begin
                    send(rand_item());
                    sent++;
                end
                1: begin
                    send(tick());
                    sent++;
                end
                default: send_message(sent);
            endcase
        end
    endtask

    initial begin
        steady      = 1'b0;
        hold_rx     = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        foreach (senders[i]) senders[i] = {$urandom, $urandom};
        senders[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        foreach (refs[i]) refs[i] = 16'($urandom);
        refs[3] = 16'hFFFF;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: singles of every flavor, at reset timeout.
        send(frag(1'b0, 16'h0000, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0));
        send(frag(1'b0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send(frag(1'b1, 16'h1234, 64'h5555, 8'd1, 8'd1, 8'h11, 1'b1));    // one-part total
        send(frag(1'b1, 16'h1234, 64'h5555, 8'd3, 8'd0, 8'h12, 1'b0));    // part zero
        // Two-part message, second part duplicated before completion.
        send(frag(1'b1, 16'h0001, 64'hAAAA, 8'd2, 8'd2, 8'h21, 1'b1));
        send(frag(1'b1, 16'h0001, 64'hAAAA, 8'd2, 8'd2, 8'h22, 1'b0));
        send(frag(1'b1, 16'h0001, 64'hAAAA, 8'd2, 8'd1, 8'h23, 1'b0));
        // Parts beyond the slot: total 12, part 12 not kept.
        send(frag(1'b1, 16'h0002, 64'hBBBB, 8'd12, 8'd12, 8'h31, 1'b1));
        send(frag(1'b1, 16'h0002, 64'hBBBB, 8'd255, 8'd255, 8'hFF, 1'b1));
        // Six keys into five slots: evict the oldest, lowest on a tie.
        for (int i = 0; i < 6; i++) begin
            send(frag(1'b1, 16'h0100 + 16'(i), 64'hC0DE, 8'd3, 8'd1, 8'(i), 1'(i)));
            if (i == 2) send(tick());
        end
        // Complete the key that took the last evicted slot.
        send(frag(1'b1, 16'h0105, 64'hC0DE, 8'd2, 8'd2, 8'h55, 1'b1));

        // Timeout of one tick: everything left flushes on the next tick.
        write_timeout(32'd1);
        send(tick());
        send(frag(1'b1, 16'h0200, 64'hD00D, 8'd4, 8'd3, 8'h66, 1'b1));
        send(tick());

        write_timeout(32'd25);
        random_phase(40, 1'b1);

        write_timeout(32'hFFFF_FFFF);
        random_phase(15, 1'b0);
        steady = 1'b1;
        random_phase(20, 1'b0);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("** fragment_reassembly_tracker: PASSED **");
        end else begin
            $display("** fragment_reassembly_tracker: FAILED **");
        end
        $finish;
    end

endmodule
